// ===== sv/vdpf_pkg.sv =====
// Shared types, request codes and mode codes of the video display port and fetch block.
package vdpf_pkg;

  localparam int VramBytes = 16384;

  typedef enum logic [1:0] {
    REQ_BUS_RD = 2'd0,
    REQ_BUS_WR = 2'd1,
    REQ_STATUS = 2'd2,
    REQ_FETCH  = 2'd3
  } req_kind_e;

  localparam logic PORT_DATA = 1'b0;
  localparam logic PORT_CTRL = 1'b1;

  localparam logic [2:0] MODE_G1   = 3'd0;
  localparam logic [2:0] MODE_TEXT = 3'd1;
  localparam logic [2:0] MODE_G2   = 3'd2;
  localparam logic [2:0] MODE_MC   = 3'd4;

  localparam logic [7:0] TEXT_LEFT  = 8'd8;
  localparam logic [7:0] TEXT_RIGHT = 8'd248;

  typedef struct packed {
    logic [1:0] req_type;
    logic       port;
    logic [7:0] write_data;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       set_collision;
    logic       set_fifth_sprite;
    logic [4:0] fifth_sprite_number;
    logic       set_frame_end;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] name_byte;
    logic [7:0] pattern_byte;
    logic [7:0] color_byte;
    logic       mode_error;
    logic [2:0] graphic_mode;
    logic       blank_screen;
    logic [3:0] backdrop_color;
    logic [3:0] text_color;
    logic       sprites_large;
    logic       sprites_magnified;
    logic       frame_irq_enable;
  } rsp_t;

endpackage

// ===== sv/vdpf_req_if.sv =====
// Request channel: valid, ready and one request payload.
interface vdpf_req_if;
  logic              valid;
  logic              ready;
  vdpf_pkg::req_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/vdpf_rsp_if.sv =====
// Result channel: valid, ready and one result payload.
interface vdpf_rsp_if;
  logic              valid;
  logic              ready;
  vdpf_pkg::rsp_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/vdpf_front.sv =====
// Front end: two-entry request queue between the bus side and the executor.
module vdpf_front (
  input  logic       clk_i,
  input  logic       rst_ni,
  vdpf_req_if.sink   req_i,
  vdpf_req_if.source deq_o
);

  vdpf_pkg::req_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign req_i.ready   = (cnt_q != 2'd2);
  assign deq_o.valid   = (cnt_q != 2'd0);
  assign deq_o.payload = slot_q[rd_ptr_q];
  assign push = req_i.valid && req_i.ready;
  assign pop  = deq_o.valid && deq_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= req_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/vdpf_back.sv =====
// Executor: port state, control registers, video memory and the pixel fetch sequencer.
module vdpf_back #(
  parameter int VRAM_BYTES = vdpf_pkg::VramBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vdpf_req_if.sink   deq_i,
  vdpf_rsp_if.source rsp_o
);

  localparam int AW = $clog2(VRAM_BYTES);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_EXEC  = 8'b0000_0100,
    S_RA    = 8'b0000_1000,
    S_NAME  = 8'b0001_0000,
    S_PAT   = 8'b0010_0000,
    S_COL   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  vdpf_pkg::req_t  cur_q;
  logic [AW-1:0]   na_q;
  logic [1:0]      third_q;
  logic            border_q;
  logic [7:0]      regs_q [8];
  logic [7:0]      regs_d [8];
  logic [AW-1:0]   addr_q, addr_d;
  logic [7:0]      ra_q, ra_d;
  logic            latch_pend_q, latch_pend_d;
  logic [7:0]      latch_q, latch_d;
  logic            coll_q, coll_d, fifth_q, fifth_d, frame_q, frame_d;
  logic [4:0]      fnum_q, fnum_d;
  logic            cv_q, cv_d;
  logic [AW-1:0]   cna_q, cna_d;
  logic [7:0]      cn_q, cn_d, cp_q, cp_d, cc_q, cc_d;
  logic [7:0]      rd_q, rd_d;
  logic            fhit_q, fhit_d;
  logic            out_valid_q, out_valid_d;
  vdpf_pkg::rsp_t  out_q, out_d;

  logic [7:0]      vram [VRAM_BYTES];
  logic [7:0]      mem_rdata_q;
  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  logic [7:0]      mem_wdata;

  logic [2:0]      mode;
  logic            bad;
  logic            pop;
  logic [AW-1:0]   name_base, pat_base, col_base;
  logic [AW-1:0]   new_addr;

  // Name address of the request at the head of the queue.
  vdpf_pkg::req_t  hd;
  logic [7:0]      xm8;
  logic [15:0]     div_prod;
  logic [5:0]      q6;
  logic [4:0]      ys;
  logic [10:0]     cell_t, cell_idx;
  logic [9:0]      cell_g;

  assign mode = {regs_q[1][3], regs_q[0][1], regs_q[1][4]};
  assign bad  = !(mode == vdpf_pkg::MODE_G1 || mode == vdpf_pkg::MODE_TEXT ||
                  mode == vdpf_pkg::MODE_G2 || mode == vdpf_pkg::MODE_MC);
  assign name_base = AW'({regs_q[2][3:0], 10'b0});
  assign pat_base  = AW'({regs_q[4][2:0], 11'b0});
  assign col_base  = AW'({regs_q[3], 6'b0});

  assign hd       = deq_i.payload;
  assign xm8      = hd.pixel_x - vdpf_pkg::TEXT_LEFT;
  // Divide by six: times 171 over 1024 is exact for values below 240.
  assign div_prod = 16'(xm8) * 16'd171;
  assign q6       = div_prod[15:10];
  assign ys       = hd.pixel_y[7:3];
  assign cell_t   = (11'(ys) << 5) + (11'(ys) << 3) + 11'(q6);
  assign cell_g   = {ys, hd.pixel_x[7:3]};
  assign cell_idx = (mode == vdpf_pkg::MODE_TEXT) ? cell_t : 11'(cell_g);

  assign deq_i.ready   = (state_q == S_IDLE) && !out_valid_q;
  assign pop           = deq_i.valid && deq_i.ready;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vram[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= vram[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q    <= hd;
      na_q     <= AW'(name_base + AW'(cell_idx));
      third_q  <= cell_g[9:8];
      border_q <= (hd.pixel_x < vdpf_pkg::TEXT_LEFT) || (hd.pixel_x >= vdpf_pkg::TEXT_RIGHT);
    end
    out_q <= out_d;
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    regs_d       = regs_q;
    addr_d       = addr_q;
    ra_d         = ra_q;
    latch_pend_d = latch_pend_q;
    latch_d      = latch_q;
    coll_d       = coll_q;
    fifth_d      = fifth_q;
    fnum_d       = fnum_q;
    frame_d      = frame_q;
    cv_d         = cv_q;
    cna_d        = cna_q;
    cn_d         = cn_q;
    cp_d         = cp_q;
    cc_d         = cc_q;
    rd_d         = rd_q;
    fhit_d       = fhit_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_addr     = addr_q;
    mem_wdata    = '0;
    new_addr     = AW'({cur_q.write_data[5:0], latch_q});

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(VRAM_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) state_d = S_EXEC;
      end
      S_EXEC: begin
        rd_d    = '0;
        fhit_d  = 1'b0;
        state_d = S_DONE;
        case (vdpf_pkg::req_kind_e'(cur_q.req_type))
          vdpf_pkg::REQ_BUS_RD: begin
            if (cur_q.port == vdpf_pkg::PORT_DATA) begin
              rd_d     = ra_q;
              mem_addr = addr_q;
              addr_d   = addr_q + 1'b1;
              state_d  = S_RA;
            end else begin
              rd_d = {frame_q, fifth_q, coll_q, fifth_q ? fnum_q : 5'd0};
              coll_d       = 1'b0;
              frame_d      = 1'b0;
              latch_pend_d = 1'b0;
            end
          end
          vdpf_pkg::REQ_BUS_WR: begin
            if (cur_q.port == vdpf_pkg::PORT_DATA) begin
              ra_d      = cur_q.write_data;
              mem_we    = 1'b1;
              mem_addr  = addr_q;
              mem_wdata = cur_q.write_data;
              addr_d    = addr_q + 1'b1;
            end else if (latch_pend_q) begin
              addr_d       = new_addr;
              latch_pend_d = 1'b0;
              if (cur_q.write_data[7]) begin
                regs_d[cur_q.write_data[2:0]] = latch_q;
                if (cur_q.write_data[2:1] == 2'b00) cv_d = 1'b0;
              end else if (!cur_q.write_data[6]) begin
                mem_addr = new_addr;
                addr_d   = new_addr + 1'b1;
                state_d  = S_RA;
              end
            end else begin
              latch_pend_d = 1'b1;
              latch_d      = cur_q.write_data;
            end
          end
          vdpf_pkg::REQ_STATUS: begin
            if (cur_q.set_collision) coll_d = 1'b1;
            if (cur_q.set_fifth_sprite) begin
              fifth_d = 1'b1;
              fnum_d  = cur_q.fifth_sprite_number;
            end
            if (cur_q.set_frame_end) frame_d = 1'b1;
          end
          vdpf_pkg::REQ_FETCH: begin
            if (bad) begin
              fhit_d = 1'b0;
            end else if (mode == vdpf_pkg::MODE_TEXT && border_q) begin
              cv_d = 1'b0;
            end else begin
              fhit_d = 1'b1;
              if (!(cv_q && na_q == cna_q)) begin
                cna_d    = na_q;
                mem_addr = na_q;
                state_d  = S_NAME;
              end
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RA: begin
        ra_d    = mem_rdata_q;
        state_d = S_DONE;
      end
      S_NAME: begin
        cn_d = mem_rdata_q;
        case (mode)
          vdpf_pkg::MODE_MC: mem_addr = AW'(pat_base + AW'({mem_rdata_q, 3'b0}) +
                                            AW'({cur_q.pixel_y[4:3], cur_q.pixel_y[2]}));
          vdpf_pkg::MODE_G2: mem_addr = AW'(pat_base + AW'({third_q, 11'b0}) +
                                            AW'({mem_rdata_q, 3'b0}) +
                                            AW'(cur_q.pixel_y[2:0]));
          default:           mem_addr = AW'(pat_base + AW'({mem_rdata_q, 3'b0}) +
                                            AW'(cur_q.pixel_y[2:0]));
        endcase
        state_d = S_PAT;
      end
      S_PAT: begin
        cp_d = mem_rdata_q;
        case (mode)
          vdpf_pkg::MODE_TEXT: begin
            cc_d    = '0;
            cv_d    = 1'b1;
            state_d = S_DONE;
          end
          vdpf_pkg::MODE_MC: begin
            cc_d    = mem_rdata_q;
            cv_d    = 1'b1;
            state_d = S_DONE;
          end
          vdpf_pkg::MODE_G2: begin
            mem_addr = AW'(col_base + AW'({third_q, 11'b0}) + AW'({cn_q, 3'b0}) +
                           AW'(cur_q.pixel_y[2:0]));
            state_d  = S_COL;
          end
          default: begin
            mem_addr = AW'(col_base + AW'(cn_q[7:3]));
            state_d  = S_COL;
          end
        endcase
      end
      S_COL: begin
        cc_d    = mem_rdata_q;
        cv_d    = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        out_valid_d             = 1'b1;
        out_d.read_data         = rd_q;
        out_d.name_byte         = fhit_q ? cn_q : 8'd0;
        out_d.pattern_byte      = fhit_q ? cp_q : 8'd0;
        out_d.color_byte        = fhit_q ? cc_q : 8'd0;
        out_d.mode_error        = bad;
        out_d.graphic_mode      = mode;
        out_d.blank_screen      = ~regs_q[1][6];
        out_d.backdrop_color    = regs_q[7][3:0];
        out_d.text_color        = regs_q[7][7:4];
        out_d.sprites_large     = regs_q[1][1];
        out_d.sprites_magnified = regs_q[1][0];
        out_d.frame_irq_enable  = regs_q[1][5];
        state_d                 = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      regs_q       <= '{default: '0};
      addr_q       <= '0;
      ra_q         <= '0;
      latch_pend_q <= 1'b0;
      latch_q      <= '0;
      coll_q       <= 1'b0;
      fifth_q      <= 1'b0;
      fnum_q       <= '0;
      frame_q      <= 1'b0;
      cv_q         <= 1'b0;
      cna_q        <= '0;
      cn_q         <= '0;
      cp_q         <= '0;
      cc_q         <= '0;
      rd_q         <= '0;
      fhit_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      regs_q       <= regs_d;
      addr_q       <= addr_d;
      ra_q         <= ra_d;
      latch_pend_q <= latch_pend_d;
      latch_q      <= latch_d;
      coll_q       <= coll_d;
      fifth_q      <= fifth_d;
      fnum_q       <= fnum_d;
      frame_q      <= frame_d;
      cv_q         <= cv_d;
      cna_q        <= cna_d;
      cn_q         <= cn_d;
      cp_q         <= cp_d;
      cc_q         <= cc_d;
      rd_q         <= rd_d;
      fhit_q       <= fhit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !deq_i.ready)
    else $error("request taken during memory clear");

  a_col_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COL |=> state_q == S_DONE && cv_q)
    else $error("colour read did not complete the fetch");

  a_status_clears_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && cur_q.req_type == vdpf_pkg::REQ_BUS_RD &&
     cur_q.port == vdpf_pkg::PORT_CTRL) |=> !latch_pend_q && !coll_q && !frame_q)
    else $error("status read left latch or flags set");

  a_done_posts_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> out_valid_q)
    else $error("finished request produced no result");

endmodule

// ===== sv/video_display_port_and_fetch.sv =====
// Top level of the video display port and pixel fetch block.
// After reset the block sweeps its 16K video memory (VRAM_BYTES bytes, 16384
// by default) to zero, one byte per cycle, and executes no request until the
// sweep ends. Requests enter a two-entry queue and are executed one at a
// time by a sequencer that owns the single-port video memory. A status event,
// status read, register write, cache hit, text-border fetch or unsupported-mode
// fetch goes from the execute state straight to done; a data-port read or
// prefetch passes through a memory read state first; a pixel fetch that misses
// the name cache reads the name, then the pattern, then in the graphics modes
// the colour: these reads share the one memory port, so each has a state of its
// own. A finished result sits in an output register while the queue keeps
// taking new requests.
module video_display_port_and_fetch #(
  parameter int VRAM_BYTES = vdpf_pkg::VramBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vdpf_req_if.sink   req_i,
  vdpf_rsp_if.source rsp_o
);

  // Queue between the front end and the executor.
  vdpf_req_if q_if ();

  vdpf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .deq_o  (q_if.source)
  );

  // Execute requests against memory, registers and flags; hold the result.
  vdpf_back #(
    .VRAM_BYTES (VRAM_BYTES)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .deq_i  (q_if.sink),
    .rsp_o  (rsp_o)
  );

endmodule
